[rtl/miller_rabin_prime_test_core_assert.svh]
// ----------------------------------------------------------------------------
// Miller-Rabin core assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_PRIME_TEST_CORE_ASSERT_SVH
`define MILLER_RABIN_PRIME_TEST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MRP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MRP_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MRP_ASSERT(label, clk, rst_n, prop, msg)
`define MRP_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

[rtl/mrp_pkg.sv]
// ----------------------------------------------------------------------------
// Miller-Rabin core package
// Widths, register indexes, constants, FSM type and the witness LFSR step.
// ----------------------------------------------------------------------------
package mrp_pkg;

	localparam int NUM_WIDTH = 32;
	localparam int CAND_W    = 32;
	localparam int ROUND_W   = 5;
	localparam int LFSR_W    = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_CNT_W = $clog2(LFSR_W + 1);

	typedef logic [NUM_WIDTH-1:0] num_t;
	typedef logic [LFSR_W-1:0]    lfsr_t;

	localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = CFG_IDX_W'(1);

	localparam logic [ROUND_W-1:0] ROUND_RESET = ROUND_W'(4);
	localparam lfsr_t              SEED_RESET  = LFSR_W'(1);
	localparam lfsr_t              LFSR_TAPS   = 32'h8020_0003;

	localparam num_t NUM_ONE   = NUM_WIDTH'(1);
	localparam num_t NUM_TWO   = NUM_WIDTH'(2);
	localparam num_t NUM_THREE = NUM_WIDTH'(3);
	localparam num_t NUM_FOUR  = NUM_WIDTH'(4);

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_STRIP,
		ST_ROUND,
		ST_DIV,
		ST_PMUL,
		ST_PWAIT_A,
		ST_PSHIFT,
		ST_PWAIT_B,
		ST_TEST0,
		ST_SQ,
		ST_SQWAIT,
		ST_SQTEST
	} state_t;

	function automatic lfsr_t lfsr_next(input lfsr_t cur);
		lfsr_t taps;
		taps = cur[0] ? LFSR_TAPS : '0;
		return (cur >> 1) ^ taps;
	endfunction

endpackage

[rtl/mrp_modmul.sv]
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Shift-and-add (a * b) mod n, one multiplier bit per cycle; a, b < n.
// ----------------------------------------------------------------------------
module mrp_modmul import mrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  num_t       a,
	input  num_t       b,
	input  num_t       n,
	output unit_stat_t stat,
	output num_t       product
);

	num_t a_q;
	num_t b_q;
	num_t n_q;
	num_t acc_q;
	logic busy_q;
	logic done_q;

	function automatic num_t mod_add(input num_t x, input num_t y, input num_t m);
		num_t gap;
		gap = m - y;
		return (x >= gap) ? (x - gap) : (x + y);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (b_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			n_q   <= n;
			acc_q <= '0;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= mod_add(acc_q, a_q, n_q);
			end
			a_q <= mod_add(a_q, a_q, n_q);
			b_q <= b_q >> 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = acc_q;

endmodule

[rtl/mrp_moddiv.sv]
// ----------------------------------------------------------------------------
// Bit-serial remainder unit
// Restoring r mod m, one dividend bit per cycle, MSB first; m nonzero.
// ----------------------------------------------------------------------------
module mrp_moddiv import mrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  lfsr_t      r,
	input  num_t       m,
	output unit_stat_t stat,
	output num_t       rem
);

	lfsr_t                r_q;
	num_t                 m_q;
	num_t                 rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [NUM_WIDTH:0]   trial;

	assign trial = {rem_q, r_q[LFSR_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(LFSR_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= r;
			m_q   <= m;
			rem_q <= '0;
		end else if (busy_q) begin
			r_q <= r_q << 1;
			if (trial >= {1'b0, m_q}) begin
				rem_q <= NUM_WIDTH'(trial - {1'b0, m_q});
			end else begin
				rem_q <= trial[NUM_WIDTH-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

endmodule

[rtl/miller_rabin_prime_test_core.sv]
// ----------------------------------------------------------------------------
// Miller-Rabin prime test core
// Candidates 0..4 are settled in the check state; otherwise each round takes a witness
// remainder plus up to (2*NUM_WIDTH + s) modular products in the bit-serial multiplier.
// One candidate at a time; busy is high from accept until done, and the next start
// is taken in the cycle done is high. Results cannot be stalled.
// Reset: idle, round_count = 4, witness LFSR = 1.
// ----------------------------------------------------------------------------
`include "miller_rabin_prime_test_core_assert.svh"

module miller_rabin_prime_test_core import mrp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [CAND_W-1:0]    candidate,
	output logic                 done,
	output logic                 probably_prime,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data
);

	state_t               state_q;
	state_t               state_d;
	logic [ROUND_W-1:0]   round_count_q;
	logic [ROUND_W-1:0]   rnd_q;
	lfsr_t                lfsr_q;
	logic                 done_q;
	logic                 prime_q;

	num_t                 n_q;
	num_t                 d_q;
	num_t                 e_q;
	num_t                 base_q;
	num_t                 acc_q;
	num_t                 nm1;
	num_t                 div_mod;

	logic                 mm_start;
	num_t                 mm_a;
	num_t                 mm_b;
	num_t                 mm_prod;
	unit_stat_t           mm_stat;
	logic                 div_start;
	num_t                 div_rem;
	unit_stat_t           div_stat;
	logic                 lfsr_step;
	logic                 fin;
	logic                 fin_val;

	assign nm1     = n_q - NUM_ONE;
	assign div_mod = n_q - NUM_FOUR;

	mrp_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.a       (mm_a),
		.b       (mm_b),
		.n       (n_q),
		.stat    (mm_stat),
		.product (mm_prod)
	);

	mrp_moddiv u_moddiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.r      (lfsr_next(lfsr_q)),
		.m      (div_mod),
		.stat   (div_stat),
		.rem    (div_rem)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (start) state_d = ST_CHECK;
			ST_CHECK:   state_d = fin ? ST_IDLE : ST_STRIP;
			ST_STRIP:   if (d_q[0]) state_d = ST_ROUND;
			ST_ROUND:   state_d = fin ? ST_IDLE : ST_DIV;
			ST_DIV:     if (div_stat.done) state_d = ST_PMUL;
			ST_PMUL:    state_d = e_q[0] ? ST_PWAIT_A : ST_PSHIFT;
			ST_PWAIT_A: if (mm_stat.done) state_d = ST_PSHIFT;
			ST_PSHIFT:  state_d = mm_start ? ST_PWAIT_B : ST_TEST0;
			ST_PWAIT_B: if (mm_stat.done) state_d = ST_PMUL;
			ST_TEST0:   state_d = ((acc_q == NUM_ONE) || (acc_q == nm1)) ? ST_ROUND : ST_SQ;
			ST_SQ:      state_d = fin ? ST_IDLE : ST_SQWAIT;
			ST_SQWAIT:  if (mm_stat.done) state_d = ST_SQTEST;
			ST_SQTEST: begin
				if (fin) begin
					state_d = ST_IDLE;
				end else begin
					state_d = (acc_q == nm1) ? ST_ROUND : ST_SQ;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mm_start  = 1'b0;
		mm_a      = acc_q;
		mm_b      = acc_q;
		div_start = 1'b0;
		lfsr_step = 1'b0;
		fin       = 1'b0;
		fin_val   = 1'b0;
		unique case (state_q)
			ST_CHECK: begin
				if ((n_q <= NUM_ONE) || (n_q == NUM_FOUR)) begin
					fin = 1'b1;
				end else if (n_q <= NUM_THREE) begin
					fin     = 1'b1;
					fin_val = 1'b1;
				end
			end
			ST_ROUND: begin
				if (rnd_q == round_count_q) begin
					fin     = 1'b1;
					fin_val = 1'b1;
				end else begin
					div_start = 1'b1;
					lfsr_step = 1'b1;
				end
			end
			ST_PMUL: begin
				mm_start = e_q[0];
				mm_b     = base_q;
			end
			ST_PSHIFT: begin
				mm_start = (e_q[NUM_WIDTH-1:1] != '0);
				mm_a     = base_q;
				mm_b     = base_q;
			end
			ST_SQ: begin
				if (e_q == nm1) begin
					fin = 1'b1;
				end else begin
					mm_start = 1'b1;
				end
			end
			ST_SQTEST: begin
				if (acc_q == NUM_ONE) begin
					fin = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			round_count_q <= ROUND_RESET;
			lfsr_q        <= SEED_RESET;
			rnd_q         <= '0;
			done_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (wr_en && (wr_index == REG_ROUND_COUNT)) begin
				round_count_q <= wr_data[ROUND_W-1:0];
			end
			if (wr_en && (wr_index == REG_RANDOM_SEED)) begin
				lfsr_q <= (wr_data[LFSR_W-1:0] != '0) ? wr_data[LFSR_W-1:0] : SEED_RESET;
			end else if (lfsr_step) begin
				lfsr_q <= lfsr_next(lfsr_q);
			end
			if ((state_q == ST_IDLE) && start) begin
				rnd_q <= '0;
			end else if (div_start) begin
				rnd_q <= rnd_q + ROUND_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			prime_q <= fin_val;
		end
		unique case (state_q)
			ST_IDLE:    if (start) n_q <= NUM_WIDTH'(candidate);
			ST_CHECK:   d_q <= nm1;
			ST_STRIP:   if (!d_q[0]) d_q <= d_q >> 1;
			ST_DIV: begin
				if (div_stat.done) begin
					base_q <= NUM_TWO + div_rem;
					acc_q  <= NUM_ONE;
					e_q    <= d_q;
				end
			end
			ST_PWAIT_A: if (mm_stat.done) acc_q <= mm_prod;
			ST_PSHIFT:  e_q <= e_q >> 1;
			ST_PWAIT_B: if (mm_stat.done) base_q <= mm_prod;
			ST_TEST0:   e_q <= d_q;
			ST_SQWAIT: begin
				if (mm_stat.done) begin
					acc_q <= mm_prod;
					e_q   <= e_q << 1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign probably_prime = prime_q;

	`MRP_ASSERT(a_done_pulse, clk, arst_n, done_q |=> !done_q, "result strobe longer than one cycle")
	`MRP_ASSERT(a_start_busy, clk, arst_n, (start && !busy) |=> busy, "transfer accepted but core not busy")
	`MRP_ASSERT_NEVER(a_mm_overlap, clk, arst_n, mm_start && mm_stat.busy, "multiplier restarted while busy")
	`MRP_ASSERT_NEVER(a_div_overlap, clk, arst_n, div_start && div_stat.busy, "divider restarted while busy")
	`MRP_ASSERT(a_rem_range, clk, arst_n, div_stat.done |-> (div_rem < div_mod), "witness remainder out of range")

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Miller-Rabin prime test core testbench
// Sends candidates through the start/busy handshake and predicts each verdict
// with a local model of the witness LFSR and the witness rounds. Covers the
// corner values, strong pseudoprimes, round counts 0/1/16/31, seed handling,
// and random primes, semiprimes and raw values under several settings.
// ----------------------------------------------------------------------------
module tb_top import mrp_pkg::*; ();

	// worst case: every item a prime at 16 rounds, plus one
	// 31-round item and sender gaps; taken several times over
	localparam int unsigned CYCLE_LIMIT = 30_000_000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

	typedef struct {
		num_t cand;
		logic prime;
	} verdict_t;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 start          = 1'b0;
	logic [CAND_W-1:0]    candidate      = '0;
	logic                 wr_en          = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index       = '0;
	logic [CFG_W-1:0]     wr_data        = '0;
	logic                 busy;
	logic                 done;
	logic                 probably_prime;

	verdict_t             pending_verdicts[$];
	logic [ROUND_W-1:0]   model_rounds;
	lfsr_t                model_lfsr;
	bit                   gaps_on;
	int unsigned          mismatch_count;
	int unsigned          cycle_count;

	miller_rabin_prime_test_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.candidate      (candidate),
		.done           (done),
		.probably_prime (probably_prime),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------- verdict prediction ----------------

	function automatic num_t mul_mod(input num_t a, input num_t b, input num_t n);
		logic [2*NUM_WIDTH-1:0] prod;
		prod = {{NUM_WIDTH{1'b0}}, a} * {{NUM_WIDTH{1'b0}}, b};
		return num_t'(prod % {{NUM_WIDTH{1'b0}}, n});
	endfunction

	function automatic num_t pow_mod(input num_t base, input num_t e, input num_t n);
		num_t acc;
		num_t sq;
		acc = NUM_ONE % n;
		sq  = base % n;
		while (e != 0) begin
			if (e[0])
				acc = mul_mod(acc, sq, n);
			e  = e >> 1;
			sq = mul_mod(sq, sq, n);
		end
		return acc;
	endfunction

	function automatic logic predict_verdict(input num_t n);
		num_t        d;
		num_t        dd;
		num_t        witness;
		num_t        x;
		bit          composite;
		int unsigned i;
		if (n <= NUM_ONE || n == NUM_FOUR)
			return 1'b0;
		if (n <= NUM_THREE)
			return 1'b1;
		d = n - NUM_ONE;
		while (!d[0])
			d = d >> 1;
		for (i = 0; i < model_rounds; i++) begin
			model_lfsr = (model_lfsr >> 1) ^ (model_lfsr[0] ? LFSR_TAPS : '0);
			witness = NUM_TWO + (model_lfsr % (n - NUM_FOUR));
			x = pow_mod(witness, d, n);
			if (x == NUM_ONE || x == n - NUM_ONE)
				continue;
			composite = 1'b1;
			dd = d;
			while (dd != n - NUM_ONE) begin
				x  = mul_mod(x, x, n);
				dd = dd << 1;
				if (x == NUM_ONE)
					break;
				if (x == n - NUM_ONE) begin
					composite = 1'b0;
					break;
				end
			end
			if (composite)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic bit is_prime(input num_t n);
		longint unsigned f;
		if (n < 2)
			return 1'b0;
		if (n < 4)
			return 1'b1;
		if (!n[0])
			return 1'b0;
		for (f = 3; f * f <= n; f += 2)
			if (n % f == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic num_t random_prime(input int unsigned bits);
		num_t v;
		v = num_t'($urandom & ((64'd1 << bits) - 64'd1)) | (num_t'(1) << (bits - 1)) | NUM_ONE;
		while (!is_prime(v)) begin
			if (v >= 32'hFFFF_FFFB)
				return 32'hFFFF_FFFB;
			v = v + NUM_TWO;
		end
		return v;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		case (idx)
			REG_ROUND_COUNT: model_rounds = data[ROUND_W-1:0];
			REG_RANDOM_SEED: model_lfsr = (data == '0) ? SEED_RESET : lfsr_t'(data);
			default: ;
		endcase
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic submit_candidate(input num_t n);
		int unsigned gap;
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 16);
			start <= 1'b0;
			do @(negedge clk); while (busy !== 1'b0);
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		candidate <= n;
		do @(negedge clk); while (busy !== 1'b0);
		@(posedge clk);
		pending_verdicts.push_back('{n, predict_verdict(n)});
	endtask

	task automatic drain(input int unsigned settle);
		start <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// ---------------- result checking ----------------

	always @(negedge clk) begin : check_results
		verdict_t head;
		if (arst_n && done === 1'b1) begin
			if (pending_verdicts.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result transfer: probably_prime=%b", probably_prime);
			end else begin
				head = pending_verdicts.pop_front();
				if (probably_prime !== head.prime) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("candidate %0d: expected %b, got %b",
							head.cand, head.prime, probably_prime);
				end
			end
		end
	end

	// ---------------- tests ----------------

	task automatic test_corner_cases();
		num_t values[$];
		values = '{0, 1, 2, 3, 4, 5, 6, 7, 9, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
			32'h8000_0000, 32'hFFFF_FFFB};
		foreach (values[i])
			submit_candidate(values[i]);
		drain(8);
	endtask

	task automatic test_pseudoprimes();
		write_reg(REG_ROUND_COUNT, 32'd1);
		submit_candidate(32'd561);
		submit_candidate(32'd2047);
		submit_candidate(32'd25326001);
		submit_candidate(32'd3215031751);
		drain(8);
	endtask

	task automatic test_round_limits();
		// upper bits of the write are dropped: this is zero rounds
		write_reg(REG_ROUND_COUNT, 32'hFFFF_FFE0);
		submit_candidate(32'd9);
		submit_candidate(32'd97);
		drain(8);
		write_reg(REG_ROUND_COUNT, 32'd31);
		submit_candidate(32'd65537);
		drain(8);
		write_reg(REG_ROUND_COUNT, 32'd16);
		submit_candidate(32'hFFFF_FFFB);
		drain(8);
		write_reg(REG_ROUND_COUNT, 32'd4);
	endtask

	task automatic test_seed_handling();
		write_reg(REG_RANDOM_SEED, 32'd0);
		submit_candidate(32'd1000003);
		drain(8);
		write_reg(REG_SPARE_2, $urandom);
		write_reg(REG_SPARE_3, $urandom);
		submit_candidate(32'd1000003);
		drain(8);
		write_reg(REG_RANDOM_SEED, 32'hFFFF_FFFF);
		submit_candidate(32'd25326001);
		drain(8);
		write_reg(REG_RANDOM_SEED, 32'd1);
		submit_candidate(32'd1373653);
		drain(8);
	endtask

	task automatic test_random_mix();
		int unsigned phase;
		int unsigned k;
		int unsigned rounds;
		num_t        n;
		for (phase = 0; phase < 5; phase++) begin
			gaps_on = (phase < 4);
			rounds = (phase == 2) ? 16 : $urandom_range(1, 5);
			write_reg(REG_ROUND_COUNT, CFG_W'({$urandom, 5'd0}) | CFG_W'(rounds));
			write_reg(REG_RANDOM_SEED, $urandom);
			for (k = 0; k < 20; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: n = random_prime($urandom_range(3, 32));
					4, 5:       n = random_prime($urandom_range(2, 15))
						* random_prime($urandom_range(2, 15));
					6, 7:       n = $urandom;
					8:          n = $urandom_range(0, 40);
					default:    n = num_t'({$urandom, 1'b0});
				endcase
				submit_candidate(n);
			end
			drain(8);
		end
	endtask

	initial begin
		model_rounds = ROUND_RESET;
		model_lfsr   = SEED_RESET;
		gaps_on      = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		test_pseudoprimes();
		test_round_limits();
		test_seed_handling();
		test_random_mix();
		drain(100);
		if (mismatch_count == 0 && pending_verdicts.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
